// ----- rtl/fmcc_pkg.sv -----
package fmcc_pkg;

	// Default sizes
	localparam int LengthBitsDef  = 24;
	localparam int CounterBitsDef = 32;
	localparam int ApbAddrBits    = 4;

	// CRC-32, reflected form
	localparam logic [31:0] CrcPoly = 32'hEDB88320;
	localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

	// Message types
	localparam logic [31:0] MsgCaps  = 32'h0000_0001;
	localparam logic [31:0] MsgStart = 32'h0000_0003;
	localparam logic [31:0] MsgCrc   = 32'h0000_0005;
	localparam logic [31:0] MsgBlock = 32'h0000_0006;
	localparam logic [31:0] MsgStop  = 32'h0000_0008;

	// Register reset values
	localparam logic [23:0] DefaultBufSize = 24'(240 * 1024);

	// Register indexes (word address)
	localparam logic [1:0] RegBufSize  = 2'd0;
	localparam logic [1:0] RegBufReady = 2'd1;
	localparam logic [1:0] RegMaxLen   = 2'd2;

	typedef enum logic [3:0] {
		EV_CAPS      = 4'd0,
		EV_ACK       = 4'd1,
		EV_TOO_LARGE = 4'd2,
		EV_NO_BUFFER = 4'd3,
		EV_CRC_STORE = 4'd4,
		EV_CRC_OK    = 4'd5,
		EV_CRC_BAD   = 4'd6,
		EV_STOP      = 4'd7,
		EV_UNKNOWN   = 4'd8,
		EV_OVERLONG  = 4'd9,
		EV_SHORT     = 4'd10
	} event_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       session_reset;
	} fmcc_in_t;

	typedef struct packed {
		event_t      event_res;
		logic [31:0] value_first;
		logic [31:0] value_second;
		logic [31:0] error_total;
		logic [31:0] blocks_received;
	} fmcc_out_t;

	typedef struct packed {
		logic [23:0] buffer_size;
		logic        buffer_ready;
		logic [23:0] max_message_length;
	} fmcc_cfg_t;

	// One byte through the reflected CRC-32
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/fmcc_cfg_regs.sv -----
module fmcc_cfg_regs import fmcc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ApbAddrBits-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output fmcc_cfg_t              cfg
);

	logic [23:0] buf_size_q;
	logic        buf_ready_q;
	logic [23:0] max_len_q;
	logic        wr_en;
	logic [1:0]  reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel & penable & pwrite;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_size_q  <= DefaultBufSize;
			buf_ready_q <= 1'b1;
			max_len_q   <= DefaultBufSize;
		end else if (wr_en) begin
			unique case (reg_idx)
				RegBufSize:  buf_size_q  <= pwdata[23:0];
				RegBufReady: buf_ready_q <= pwdata[0];
				RegMaxLen:   max_len_q   <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (reg_idx)
			RegBufSize:  prdata = {8'd0, buf_size_q};
			RegBufReady: prdata = {31'd0, buf_ready_q};
			RegMaxLen:   prdata = {8'd0, max_len_q};
			default:     prdata = 32'd0;
		endcase
	end

	assign cfg = '{buffer_size: buf_size_q, buffer_ready: buf_ready_q,
		max_message_length: max_len_q};

endmodule

// ----- rtl/fmcc_core.sv -----
module fmcc_core import fmcc_pkg::*; #(
	parameter int LENGTH_BITS  = LengthBitsDef,
	parameter int COUNTER_BITS = CounterBitsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  fmcc_in_t  item,
	input  fmcc_cfg_t cfg,
	output logic      res_valid,
	output fmcc_out_t res
);

	localparam logic [32:0] LenMax = (33'd1 << LENGTH_BITS) - 33'd1;

	// Parser and session state
	logic                    in_payload_q, in_payload_d;
	logic [2:0]              hdr_cnt_q, hdr_cnt_d;
	logic [63:0]             hdr_q, hdr_d;
	logic [LENGTH_BITS-1:0]  remain_q, remain_d;
	logic [31:0]             prefix_q, prefix_d;
	logic [2:0]              pfx_cnt_q, pfx_cnt_d;
	logic [31:0]             crc_q, crc_d;
	logic [31:0]             expected_q, expected_d;
	logic [COUNTER_BITS-1:0] blocks_q, blocks_d;
	logic [COUNTER_BITS-1:0] mism_q, mism_d;
	logic                    halted_q, halted_d;

	// Per-byte values
	logic [63:0] hdr_nx;
	logic [31:0] pfx_nx;
	logic [31:0] crc_nx;
	logic [31:0] frame_type;
	logic [31:0] msg_len;
	logic [31:0] fin_pfx;
	logic [31:0] fin_crc;
	logic        hdr_done;
	logic        pay_done;
	logic        overlong;
	logic        finish;

	assign hdr_nx     = {hdr_q[55:0], item.rx_byte};
	assign pfx_nx     = (pfx_cnt_q < 3'd4) ? {prefix_q[23:0], item.rx_byte} : prefix_q;
	assign crc_nx     = crc32_byte(crc_q, item.rx_byte);
	assign hdr_done   = !in_payload_q && (hdr_cnt_q == 3'd7);
	assign pay_done   = in_payload_q && (remain_q == LENGTH_BITS'(1));
	assign frame_type = in_payload_q ? hdr_q[63:32] : hdr_nx[63:32];
	assign msg_len    = in_payload_q ? hdr_q[31:0] : hdr_nx[31:0];
	assign fin_pfx    = in_payload_q ? pfx_nx : 32'd0;
	assign fin_crc    = in_payload_q ? crc_nx : CrcOnes;
	assign overlong   = hdr_done && (({1'b0, msg_len} > LenMax) ||
		(msg_len > {8'd0, cfg.max_message_length}));
	assign finish     = pay_done || (hdr_done && !overlong && (msg_len == 32'd0));

	// Next state and result
	always_comb begin
		logic [31:0] calc;
		calc         = ~fin_crc;
		in_payload_d = in_payload_q;
		hdr_cnt_d    = hdr_cnt_q;
		hdr_d        = hdr_q;
		remain_d     = remain_q;
		prefix_d     = prefix_q;
		pfx_cnt_d    = pfx_cnt_q;
		crc_d        = crc_q;
		expected_d   = expected_q;
		blocks_d     = blocks_q;
		mism_d       = mism_q;
		halted_d     = halted_q;
		res_valid    = 1'b0;
		res          = '0;
		if (fire) begin
			if (item.session_reset) begin
				in_payload_d = 1'b0;
				hdr_cnt_d    = '0;
				hdr_d        = '0;
				remain_d     = '0;
				prefix_d     = '0;
				pfx_cnt_d    = '0;
				crc_d        = CrcOnes;
				expected_d   = '0;
				blocks_d     = '0;
				mism_d       = '0;
				halted_d     = 1'b0;
			end else if (!halted_q) begin
				if (in_payload_q) begin
					prefix_d  = pfx_nx;
					pfx_cnt_d = (pfx_cnt_q < 3'd4) ? pfx_cnt_q + 3'd1 : pfx_cnt_q;
					crc_d     = crc_nx;
					remain_d  = remain_q - LENGTH_BITS'(1);
				end else begin
					hdr_d     = hdr_nx;
					hdr_cnt_d = hdr_cnt_q + 3'd1;
					if (hdr_done) begin
						prefix_d  = '0;
						pfx_cnt_d = '0;
						crc_d     = CrcOnes;
						if (overlong) begin
							halted_d        = 1'b1;
							res_valid       = 1'b1;
							res.event_res   = EV_OVERLONG;
							res.value_first = msg_len;
						end else if (msg_len != 32'd0) begin
							in_payload_d = 1'b1;
							remain_d     = msg_len[LENGTH_BITS-1:0];
						end
					end
				end
				// end of message
				if (finish) begin
					in_payload_d = 1'b0;
					hdr_cnt_d    = '0;
					res_valid    = 1'b1;
					unique case (frame_type)
						MsgCaps: begin
							res.event_res   = EV_CAPS;
							res.value_first = {8'd0, cfg.buffer_size};
						end
						MsgStart: begin
							if (msg_len < 32'd4) begin
								res.event_res   = EV_SHORT;
								res.value_first = msg_len;
							end else if (fin_pfx > {8'd0, cfg.buffer_size}) begin
								res.event_res    = EV_TOO_LARGE;
								res.value_first  = fin_pfx;
								res.value_second = {8'd0, cfg.buffer_size};
							end else if (!cfg.buffer_ready) begin
								res.event_res   = EV_NO_BUFFER;
								res.value_first = fin_pfx;
							end else begin
								blocks_d        = '0;
								mism_d          = '0;
								res.event_res   = EV_ACK;
								res.value_first = fin_pfx;
							end
						end
						MsgCrc: begin
							if (msg_len < 32'd4) begin
								res.event_res   = EV_SHORT;
								res.value_first = msg_len;
							end else begin
								expected_d      = fin_pfx;
								res.event_res   = EV_CRC_STORE;
								res.value_first = fin_pfx;
							end
						end
						MsgBlock: begin
							blocks_d         = blocks_q + COUNTER_BITS'(1);
							res.value_first  = calc;
							res.value_second = expected_q;
							if (calc != expected_q) begin
								mism_d        = mism_q + COUNTER_BITS'(1);
								res.event_res = EV_CRC_BAD;
							end else begin
								res.event_res = EV_CRC_OK;
							end
						end
						MsgStop: res.event_res = EV_STOP;
						default: begin
							res.event_res   = EV_UNKNOWN;
							res.value_first = frame_type;
						end
					endcase
				end
			end
		end
		res.error_total     = 32'(mism_d);
		res.blocks_received = 32'(blocks_d);
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_payload_q <= 1'b0;
			hdr_cnt_q    <= '0;
			hdr_q        <= '0;
			remain_q     <= '0;
			prefix_q     <= '0;
			pfx_cnt_q    <= '0;
			crc_q        <= CrcOnes;
			expected_q   <= '0;
			blocks_q     <= '0;
			mism_q       <= '0;
			halted_q     <= 1'b0;
		end else begin
			in_payload_q <= in_payload_d;
			hdr_cnt_q    <= hdr_cnt_d;
			hdr_q        <= hdr_d;
			remain_q     <= remain_d;
			prefix_q     <= prefix_d;
			pfx_cnt_q    <= pfx_cnt_d;
			crc_q        <= crc_d;
			expected_q   <= expected_d;
			blocks_q     <= blocks_d;
			mism_q       <= mism_d;
			halted_q     <= halted_d;
		end
	end

	// halted session stays silent until a session reset
	a_halted_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q && !item.session_reset |-> !res_valid)
		else $error("result produced while session halted");

	// overlong length halts the session
	a_overlong_halts: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.event_res == EV_OVERLONG) |=> halted_q)
		else $error("overlong length did not halt session");

	// payload phase always has bytes left
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		in_payload_q |-> (remain_q != '0))
		else $error("payload phase with zero remaining");

endmodule

// ----- rtl/framed_message_crc_checker_unit.sv -----
// A word in the input register has its result captured in the result register when that register has room.
// Throughput: one byte word per cycle unless out_stall holds a result; the byte parser
// and table-free CRC-32 step sit between the input register and the result register.
// Most bytes give no result; the last byte of a message gives exactly one.
// Reset (arst_n low, asynchronous) clears the parser, counters and both valid flags,
// and returns the configuration registers to their default values.
module framed_message_crc_checker_unit import fmcc_pkg::*; #(
	parameter int LENGTH_BITS  = LengthBitsDef,
	parameter int COUNTER_BITS = CounterBitsDef
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  fmcc_in_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output fmcc_out_t              out_data,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [ApbAddrBits-1:0] paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	fmcc_cfg_t cfg;
	fmcc_in_t  item_s1;
	logic      valid_s1;
	fmcc_out_t res_q;
	logic      res_valid_q;
	fmcc_out_t core_res;
	logic      core_valid;
	logic      adv;
	logic      fire;

	// Stage 1 moves on when the result register has room
	assign adv      = !res_valid_q || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign fire     = valid_s1 && adv;

	fmcc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	fmcc_core #(
		.LENGTH_BITS (LENGTH_BITS),
		.COUNTER_BITS(COUNTER_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.cfg      (cfg),
		.res_valid(core_valid),
		.res      (core_res)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			item_s1 <= in_data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= fire && core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= core_res;
		end
	end

	assign out_valid = res_valid_q;
	assign out_data  = res_q;

	// a stall only comes from a held word in stage 1
	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty stage 1");

	// a session reset word never yields a result
	a_reset_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && item_s1.session_reset |=> !res_valid_q)
		else $error("session reset produced a result");

	// a stalled result word holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result word changed");

endmodule

// ----- bench/framed_message_crc_checker_unit_tb.sv -----
`timescale 1ns / 100ps

module framed_message_crc_checker_unit_tb;
	import fmcc_pkg::*;

	localparam int unsigned HoldCycles   = 400;
	localparam int unsigned SettleCycles = 12;
	localparam int unsigned DrainLimit   = 200000;
	localparam int unsigned ReportLimit  = 10;
	// largest length the parser's counter can hold
	localparam logic [31:0] LenCeiling = 32'((64'd1 << LengthBitsDef) - 1);

	typedef enum logic {PH_HEADER, PH_PAYLOAD} parse_phase_t;
	// how a data block is announced beforehand
	typedef enum int unsigned {CRC_NONE, CRC_MATCH, CRC_CORRUPT} crc_plan_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	fmcc_in_t               in_data;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	fmcc_out_t              out_data;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ApbAddrBits-1:0] paddr;
	logic [31:0]            pwdata;
	logic [31:0]            prdata;
	logic                   pready;

	framed_message_crc_checker_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// traffic shaping
	int unsigned send_gap_pct;
	int unsigned stall_pct;
	int unsigned hold_requests = 0;
	int unsigned holds_served  = 0;
	int unsigned hold_left     = 0;
	int unsigned live_words    = 0;
	int unsigned error_count   = 0;

	fmcc_out_t expected_events[$];

	// register mirror
	logic [23:0] cfg_buf_size;
	logic        cfg_buf_ready;
	logic [23:0] cfg_max_len;

	// session and parser mirror
	parse_phase_t parse_ph;
	logic [2:0]   hdr_count;
	logic [63:0]  hdr_bytes;
	logic [23:0]  body_left;
	logic [31:0]  body_lead;
	logic [2:0]   lead_count;
	logic [31:0]  crc_acc;
	logic [23:0]  blk_len;
	logic [31:0]  exp_crc;
	logic         test_on;
	logic [31:0]  byte_total;
	logic [31:0]  blocks;
	logic [31:0]  mismatches;
	logic         halted;

	// receiver: random stalls, or one long hold-off when a test asks for it
	always @(posedge clk) begin
		if (holds_served != hold_requests) begin
			holds_served <= hold_requests;
			hold_left    <= HoldCycles;
			out_stall    <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// compare every delivered result with the oldest expected event
	always @(posedge clk) begin : check_results
		fmcc_out_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_events.size() == 0) begin
				error_count++;
				if (error_count <= ReportLimit)
					$display("unexpected result: ev=%0d v1=%h v2=%h err=%0d blk=%0d",
						out_data.event_res, out_data.value_first, out_data.value_second,
						out_data.error_total, out_data.blocks_received);
			end else begin
				want = expected_events.pop_front();
				if (out_data !== want) begin
					error_count++;
					if (error_count <= ReportLimit)
						$display({"result mismatch: want ev=%0d v1=%h v2=%h err=%0d blk=%0d",
							" / got ev=%0d v1=%h v2=%h err=%0d blk=%0d"},
							want.event_res, want.value_first, want.value_second,
							want.error_total, want.blocks_received,
							out_data.event_res, out_data.value_first, out_data.value_second,
							out_data.error_total, out_data.blocks_received);
				end
			end
		end
	end

	// reflected CRC-32, one data bit at a time
	function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] data);
		logic [31:0] c;
		c = acc;
		for (int i = 0; i < 8; i++)
			c = {1'b0, c[31:1]} ^ ((c[0] ^ data[i]) ? CrcPoly : 32'd0);
		return c;
	endfunction

	function automatic void clear_session();
		parse_ph    = PH_HEADER;
		hdr_count   = '0;
		hdr_bytes   = '0;
		body_left   = '0;
		body_lead   = '0;
		lead_count  = '0;
		crc_acc     = CrcOnes;
		blk_len     = '0;
		exp_crc     = '0;
		test_on     = 1'b0;
		byte_total  = '0;
		blocks      = '0;
		mismatches  = '0;
		halted      = 1'b0;
	endfunction

	function automatic void push_event(input event_t ev, input logic [31:0] v1,
			input logic [31:0] v2);
		fmcc_out_t r;
		r.event_res       = ev;
		r.value_first     = v1;
		r.value_second    = v2;
		r.error_total     = mismatches;
		r.blocks_received = blocks;
		expected_events.push_back(r);
	endfunction

	// a whole message has arrived: act on its type
	function automatic void close_message();
		logic [31:0] mtype;
		logic [31:0] mlen;
		logic [31:0] calc;
		mtype     = hdr_bytes[63:32];
		mlen      = hdr_bytes[31:0];
		parse_ph  = PH_HEADER;
		hdr_count = '0;
		if (mtype == MsgCaps) begin
			push_event(EV_CAPS, {8'd0, cfg_buf_size}, '0);
		end else if (mtype == MsgStart) begin
			if (mlen < 4) begin
				push_event(EV_SHORT, mlen, '0);
			end else if (body_lead > {8'd0, cfg_buf_size}) begin
				push_event(EV_TOO_LARGE, body_lead, {8'd0, cfg_buf_size});
			end else if (!cfg_buf_ready) begin
				push_event(EV_NO_BUFFER, body_lead, '0);
			end else begin
				blk_len     = body_lead[23:0];
				test_on     = 1'b1;
				byte_total  = '0;
				blocks      = '0;
				mismatches  = '0;
				push_event(EV_ACK, body_lead, '0);
			end
		end else if (mtype == MsgCrc) begin
			if (mlen < 4) begin
				push_event(EV_SHORT, mlen, '0);
			end else begin
				exp_crc = body_lead;
				push_event(EV_CRC_STORE, body_lead, '0);
			end
		end else if (mtype == MsgBlock) begin
			byte_total = byte_total + mlen;
			blocks     = blocks + 32'd1;
			calc       = ~crc_acc;
			if (calc != exp_crc) begin
				mismatches = mismatches + 32'd1;
				push_event(EV_CRC_BAD, calc, exp_crc);
			end else begin
				push_event(EV_CRC_OK, calc, exp_crc);
			end
		end else if (mtype == MsgStop) begin
			test_on = 1'b0;
			push_event(EV_STOP, '0, '0);
		end else begin
			push_event(EV_UNKNOWN, mtype, '0);
		end
	endfunction

	// advance the mirror by one accepted word
	function automatic void predict_word(input fmcc_in_t w);
		logic [31:0] mlen;
		if (w.session_reset) begin
			clear_session();
			return;
		end
		if (halted)
			return;
		if (parse_ph == PH_PAYLOAD) begin
			if (lead_count < 4) begin
				body_lead  = {body_lead[23:0], w.rx_byte};
				lead_count = lead_count + 3'd1;
			end
			crc_acc   = crc_step(crc_acc, w.rx_byte);
			body_left = body_left - 24'd1;
			if (body_left == 0)
				close_message();
			return;
		end
		hdr_bytes = {hdr_bytes[55:0], w.rx_byte};
		hdr_count = hdr_count + 3'd1;
		if (hdr_count != 0)
			return;
		mlen       = hdr_bytes[31:0];
		body_lead  = '0;
		lead_count = '0;
		crc_acc    = CrcOnes;
		if (mlen > {8'd0, cfg_max_len} || mlen > LenCeiling) begin
			halted   = 1'b1;
			parse_ph = PH_HEADER;
			push_event(EV_OVERLONG, mlen, '0);
		end else if (mlen == 0) begin
			close_message();
		end else begin
			body_left = mlen[23:0];
			parse_ph  = PH_PAYLOAD;
		end
	endfunction

	// offer one word, hold it until accepted, then update the mirror
	task automatic send_word(input fmcc_in_t w);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (!halted || w.session_reset)
			live_words++;
		predict_word(w);
	endtask

	task automatic send_byte(input logic [7:0] b);
		fmcc_in_t w;
		w.rx_byte       = b;
		w.session_reset = 1'b0;
		send_word(w);
	endtask

	task automatic send_reset();
		fmcc_in_t w;
		w.rx_byte       = 8'($urandom);
		w.session_reset = 1'b1;
		send_word(w);
	endtask

	task automatic send_header(input logic [31:0] mtype, input logic [31:0] mlen);
		for (int i = 3; i >= 0; i--)
			send_byte(mtype[8*i +: 8]);
		for (int i = 3; i >= 0; i--)
			send_byte(mlen[8*i +: 8]);
	endtask

	// payload starts with lead (big-endian), filled with random bytes past four
	task automatic send_frame(input logic [31:0] mtype, input logic [31:0] mlen,
			input logic [31:0] lead);
		send_header(mtype, mlen);
		for (int unsigned k = 0; k < mlen; k++)
			send_byte((k < 4) ? lead[8*(3-k) +: 8] : 8'($urandom));
	endtask

	// random data block, optionally preceded by its CRC (right or with one bit off)
	task automatic send_checked_block(input int unsigned len, input crc_plan_t plan);
		logic [7:0]  body [0:15];
		logic [31:0] acc;
		acc = CrcOnes;
		for (int unsigned k = 0; k < len; k++) begin
			body[k] = 8'($urandom);
			acc     = crc_step(acc, body[k]);
		end
		if (plan == CRC_MATCH)
			send_frame(MsgCrc, 4, ~acc);
		else if (plan == CRC_CORRUPT)
			send_frame(MsgCrc, 4, ~acc ^ (32'd1 << $urandom_range(31)));
		send_header(MsgBlock, len);
		for (int unsigned k = 0; k < len; k++)
			send_byte(body[k]);
	endtask

	// stop offering words and let every pending result drain
	task automatic quiesce();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_events.size() != 0)
			@(posedge clk);
		repeat (SettleCycles)
			@(posedge clk);
	endtask

	// APB write, then read the same register back
	task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
		logic [31:0] keep;
		case (idx)
			RegBufSize: begin
				cfg_buf_size = value[23:0];
				keep         = 32'h00FF_FFFF;
			end
			RegBufReady: begin
				cfg_buf_ready = value[0];
				keep          = 32'h0000_0001;
			end
			RegMaxLen: begin
				cfg_max_len = value[23:0];
				keep        = 32'h00FF_FFFF;
			end
			default: begin
				keep = '0;
			end
		endcase
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// straight into the read setup
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if ((prdata & keep) !== (value & keep)) begin
			error_count++;
			if (error_count <= ReportLimit)
				$display("register %0d read back %h, wrote %h", idx, prdata, value);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_message_types();
		send_frame(MsgCaps, 0, '0);
		send_frame(MsgCaps, 3, 32'hFFFF_FF00);
		send_frame(32'hFFFF_FFFF, 0, '0);
		send_frame(32'h0000_0000, 1, '0);
		send_frame(MsgStart, 4, {8'd0, DefaultBufSize});
		send_checked_block(8, CRC_MATCH);
		send_checked_block(5, CRC_CORRUPT);
		send_checked_block(0, CRC_NONE);
		send_frame(MsgStop, 0, '0);
		// blocks still count with no test running
		send_checked_block(3, CRC_MATCH);
		send_frame(MsgStart, 7, 32'h0000_0000);
		send_frame(MsgStop, 2, 32'hFFFF_0000);
	endtask

	task automatic test_special_cases();
		// short payloads on start and CRC
		send_frame(MsgStart, 3, 32'h0102_0300);
		send_frame(MsgCrc, 0, '0);
		send_frame(MsgCrc, 2, 32'hFFFF_FFFF);
		// requested size above the buffer
		send_frame(MsgStart, 4, {8'd0, DefaultBufSize} + 32'd1);
		send_frame(MsgStart, 4, 32'hFFFF_FFFF);
		// session reset inside a header, then inside a payload
		send_header(MsgCaps, '0);
		send_reset();
		send_frame(MsgCaps, 0, '0);
		send_header(MsgBlock, 6);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_reset();
		send_checked_block(4, CRC_MATCH);
		// overlong length halts everything until a session reset
		send_header(MsgCaps, {8'd0, DefaultBufSize} + 32'd1);
		send_frame(MsgCaps, 0, '0);
		send_reset();
		send_frame(MsgCaps, 0, '0);

		// no buffer, zero-sized buffer
		quiesce();
		write_register(RegBufReady, 32'd0);
		write_register(RegBufSize, 32'd0);
		send_frame(MsgStart, 4, 32'd0);
		send_frame(MsgStart, 4, 32'd1);
		send_frame(MsgCaps, 0, '0);
		// zero max length: only empty messages pass
		quiesce();
		write_register(RegMaxLen, 32'd0);
		send_frame(MsgCaps, 0, '0);
		send_header(MsgStart, 4);
		send_reset();
		// largest settings; length past the 24-bit counter
		quiesce();
		write_register(RegBufSize, 32'hFFFF_FFFF);
		write_register(RegBufReady, 32'hFFFF_FFFF);
		write_register(RegMaxLen, 32'h00FF_FFFF);
		send_frame(MsgStart, 4, 32'h00FF_FFFF);
		send_frame(MsgStart, 4, 32'h0100_0000);
		send_header(MsgBlock, 32'h0100_0000);
		send_reset();
	endtask

	// receiver holds off while the sender keeps pushing complete messages
	task automatic test_backpressure();
		quiesce();
		send_gap_pct = 0;
		hold_requests <= hold_requests + 1;
		send_reset();
		repeat (30)
			send_frame(MsgCaps, 0, '0);
	endtask

	task automatic send_random_message();
		int unsigned pick;
		int unsigned len;
		logic [31:0] lead;
		pick = $urandom_range(99);
		len  = $urandom_range(7);
		lead = $urandom;
		if (pick < 4) begin
			send_reset();
		end else if (pick < 8) begin
			// stray bytes: framing slips until the next session reset
			repeat ($urandom_range(1, 7))
				send_byte(8'($urandom));
			if ($urandom_range(2) != 0)
				send_reset();
		end else if (pick < 12) begin
			// length just past the limit, or past the counter width
			if ($urandom_range(1))
				send_header($urandom, {8'd0, cfg_max_len} + $urandom_range(1, 3));
			else
				send_header($urandom, $urandom | 32'h0100_0000);
			repeat ($urandom_range(4))
				send_byte(8'($urandom));
		end else if (pick < 36) begin
			send_checked_block($urandom_range(16), crc_plan_t'($urandom_range(2)));
		end else if (pick < 56) begin
			if ($urandom_range(7) != 0)
				len = $urandom_range(4, 7);
			case ($urandom_range(2))
				0: lead = $urandom_range(cfg_buf_size);
				1: lead = {8'd0, cfg_buf_size} + $urandom_range(1);
				default: ;
			endcase
			send_frame(MsgStart, len, lead);
		end else if (pick < 66) begin
			send_frame(MsgCrc, len, lead);
		end else if (pick < 76) begin
			send_frame(MsgCaps, $urandom_range(3), lead);
		end else if (pick < 86) begin
			send_frame(MsgStop, $urandom_range(2), lead);
		end else begin
			send_frame($urandom_range(1) ? $urandom : 32'($urandom_range(15)),
				$urandom_range(4), lead);
		end
		if (halted && $urandom_range(1))
			send_reset();
	endtask

	task automatic test_random_traffic(input int unsigned gap_pct, input int unsigned hold_pct,
			input int unsigned budget);
		int unsigned first;
		quiesce();
		case ($urandom_range(3))
			0: write_register(RegBufSize, 32'd0);
			1: write_register(RegBufSize, 32'h00FF_FFFF);
			2: write_register(RegBufSize, $urandom_range(64));
			default: write_register(RegBufSize, $urandom);
		endcase
		write_register(RegBufReady, ($urandom_range(9) != 0) ? 32'd1 : 32'd0);
		case ($urandom_range(2))
			0: write_register(RegMaxLen, 32'h00FF_FFFF);
			1: write_register(RegMaxLen, {8'd0, DefaultBufSize});
			default: write_register(RegMaxLen, $urandom_range(6, 20));
		endcase
		send_gap_pct = gap_pct;
		stall_pct <= hold_pct;
		send_reset();
		first = live_words;
		while (live_words - first < budget)
			send_random_message();
	endtask

	initial begin : run
		int unsigned waited;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		send_gap_pct = 30;
		stall_pct    = 86;
		cfg_buf_size  = DefaultBufSize;
		cfg_buf_ready = 1'b1;
		cfg_max_len   = DefaultBufSize;
		clear_session();
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_message_types();
		test_special_cases();
		test_random_traffic(30, 86, 230);
		test_backpressure();
		test_random_traffic(86, 30, 230);
		test_random_traffic(0, 0, 230);

		// drain, then give the block time to show anything extra
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (expected_events.size() != 0 && waited < DrainLimit) begin
			@(posedge clk);
			waited++;
		end
		repeat (SettleCycles)
			@(posedge clk);
		if (expected_events.size() != 0) begin
			$display("%0d expected results never arrived", expected_events.size());
			error_count += expected_events.size();
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hard stop if the block hangs
	initial begin
		#2_000_000;
		$display("run timed out");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
